FILE: hdl/masked_byte_pattern_scan_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the masked byte pattern scan unit
// Concurrent checks sampled on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCAN_UNIT_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCAN_UNIT_ASSERT_SVH

// Same-cycle implication
`define MBPS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define MBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the masked byte pattern scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

   localparam int BYTE_W    = 8;
   localparam int ADDR_W    = 32;
   localparam int DATA_W    = 64;
   localparam int MASK_W    = 16;
   localparam int LEN_W     = 5;
   localparam int CSR_IDX_W = 3;
   localparam int PAT_BYTES = 16;
   localparam int PAT_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CARE_MASK    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN  = 3'd4;

   typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern_type;

   // One byte in flight between the window shift and the decision stage
   typedef struct packed {
      logic              valid;
      logic              last;
      logic [ADDR_W-1:0] count;
   } stage_type;

endpackage

`default_nettype wire

FILE: hdl/masked_byte_pattern_scan_unit.sv
// Stages: the window cells and stage register, then the result register.
// Throughput: one byte per cycle unless the result register stalls; window
//   shift and cell compares are pipelined; a stall holds at most one byte back.
// Reset: synchronous, active high; sets the CSRs to their defaults, clears the
//   byte count and the report flag. No bytes are taken while reset is high.
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_unit
// Streams region bytes through a chain of window cells and reports the first
// masked pattern match, or not found at region end.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_scan_unit #(
   parameter int MAX_PATTERN = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [mbps_pkg::BYTE_W-1:0]    req_data_byte,
   input  wire logic                           req_last,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_found,
   output logic      [mbps_pkg::ADDR_W-1:0]    rsp_match_address,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [mbps_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mbps_pkg::DATA_W-1:0]    csr_data
);

   logic [mbps_pkg::ADDR_W-1:0]  base_ff;
   logic [mbps_pkg::DATA_W-1:0]  pat_low_ff;
   logic [mbps_pkg::DATA_W-1:0]  pat_high_ff;
   logic [mbps_pkg::MASK_W-1:0]  care_ff;
   logic [mbps_pkg::LEN_W-1:0]   len_ff;

   logic [mbps_pkg::LEN_W-1:0]   active_len;
   logic [mbps_pkg::ADDR_W-1:0]  addr_adjust;
   mbps_pkg::pattern_type        pattern;

   logic [mbps_pkg::ADDR_W-1:0]  count_ff;
   logic [mbps_pkg::ADDR_W-1:0]  count_in;
   logic [mbps_pkg::ADDR_W-1:0]  count_inc;
   mbps_pkg::stage_type          stage_ff;
   mbps_pkg::stage_type          stage_in;

   logic                         req_accept;
   logic                         advance;
   logic                         window_hit;

   logic [MAX_PATTERN-1:0][mbps_pkg::BYTE_W-1:0] chain;
   logic [MAX_PATTERN-1:0]                       mismatch;

   // ---------------------------------------------------------------- csr
   assign csr_ready = ~reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= '0;
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         care_ff     <= '1;
         len_ff      <= mbps_pkg::LEN_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mbps_pkg::CSR_BASE_ADDRESS: base_ff     <= csr_data[mbps_pkg::ADDR_W-1:0];
            mbps_pkg::CSR_PATTERN_LOW:  pat_low_ff  <= csr_data;
            mbps_pkg::CSR_PATTERN_HIGH: pat_high_ff <= csr_data;
            mbps_pkg::CSR_CARE_MASK:    care_ff     <= csr_data[mbps_pkg::MASK_W-1:0];
            mbps_pkg::CSR_PATTERN_LEN:  len_ff      <= csr_data[mbps_pkg::LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (len_ff == '0) begin
         active_len = mbps_pkg::LEN_W'(1);
      end else if (len_ff > mbps_pkg::LEN_W'(MAX_PATTERN)) begin
         active_len = mbps_pkg::LEN_W'(MAX_PATTERN);
      end else begin
         active_len = len_ff;
      end
      addr_adjust = base_ff - mbps_pkg::ADDR_W'(active_len);
      pattern     = {pat_high_ff, pat_low_ff};
   end

   // ------------------------------------------------------ input stage
   assign req_stall  = reset | (stage_ff.valid & ~advance);
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      count_inc = (count_ff == '1) ? count_ff : count_ff + mbps_pkg::ADDR_W'(1);
      count_in  = count_ff;
      stage_in  = stage_ff;
      if (req_accept) begin
         // saturate; restart the count after the final byte
         count_in       = req_last ? '0 : count_inc;
         stage_in.valid = 1'b1;
         stage_in.last  = req_last;
         stage_in.count = count_inc;
      end else if (advance) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         count_ff       <= count_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.last  <= stage_in.last;
      stage_ff.count <= stage_in.count;
   end

   // ------------------------------------------------------ window chain
   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      logic [mbps_pkg::BYTE_W-1:0] feed;
      if (j == 0) begin : g_head
         assign feed = req_data_byte;
      end else begin : g_link
         assign feed = chain[j-1];
      end
      mbps_cell #(
         .INDEX (j)
      ) u_cell (
         .clock      (clock),
         .shift_en   (req_accept),
         .byte_in    (feed),
         .pattern    (pattern),
         .care_mask  (care_ff),
         .active_len (active_len),
         .byte_out   (chain[j]),
         .mismatch   (mismatch[j])
      );
   end

   assign window_hit = ~|mismatch;

   // ------------------------------------------------------ decision
   mbps_report u_report (
      .clock             (clock),
      .reset             (reset),
      .stage             (stage_ff),
      .window_hit        (window_hit),
      .active_len        (active_len),
      .addr_adjust       (addr_adjust),
      .advance           (advance),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_match_address (rsp_match_address)
   );

endmodule

`default_nettype wire

FILE: hdl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// One window position: holds a byte, passes it to the next cell on each
// transaction, and compares it with the pattern byte aligned to its place.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                        clock,
   input  wire logic                        shift_en,
   input  wire logic [mbps_pkg::BYTE_W-1:0] byte_in,
   input  wire mbps_pkg::pattern_type       pattern,
   input  wire logic [mbps_pkg::MASK_W-1:0] care_mask,
   input  wire logic [mbps_pkg::LEN_W-1:0]  active_len,
   output logic      [mbps_pkg::BYTE_W-1:0] byte_out,
   output logic                             mismatch
);

   logic [mbps_pkg::BYTE_W-1:0]    data_ff;
   logic [mbps_pkg::BYTE_W-1:0]    pat_ff;
   logic [mbps_pkg::BYTE_W-1:0]    pat_in;
   logic                           care_ff;
   logic                           care_in;
   logic                           in_use;
   logic [mbps_pkg::LEN_W-1:0]     pat_pos;

   // Newest byte sits in cell 0, so this cell lines up with pattern byte len-1-INDEX
   always_comb begin
      in_use  = mbps_pkg::LEN_W'(INDEX) < active_len;
      pat_pos = active_len - mbps_pkg::LEN_W'(INDEX) - mbps_pkg::LEN_W'(1);
      pat_in  = pattern[pat_pos[mbps_pkg::PAT_IDX_W-1:0]];
      care_in = in_use & care_mask[pat_pos[mbps_pkg::PAT_IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= byte_in;
      end
      pat_ff  <= pat_in;
      care_ff <= care_in;
   end

   assign byte_out = data_ff;
   assign mismatch = care_ff & (data_ff != pat_ff);

endmodule

`default_nettype wire

FILE: hdl/mbps_report.sv
// ----------------------------------------------------------------------------
// mbps_report
// Decides per byte whether a found or not-found result is due, tracks the
// one-report-per-region flag and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "masked_byte_pattern_scan_unit_assert.svh"

module mbps_report (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mbps_pkg::stage_type         stage,
   input  wire logic                        window_hit,
   input  wire logic [mbps_pkg::LEN_W-1:0]  active_len,
   input  wire logic [mbps_pkg::ADDR_W-1:0] addr_adjust,
   output logic                             advance,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_found,
   output logic      [mbps_pkg::ADDR_W-1:0] rsp_match_address
);

   logic                          valid_ff;
   logic                          valid_in;
   logic                          found_ff;
   logic                          found_in;
   logic [mbps_pkg::ADDR_W-1:0]   addr_ff;
   logic [mbps_pkg::ADDR_W-1:0]   addr_in;
   logic                          reported_ff;
   logic                          reported_in;
   logic                          seen_enough;
   logic                          fire_match;
   logic                          fire_miss;

   always_comb begin
      advance     = stage.valid & (~valid_ff | ~rsp_stall);
      seen_enough = (stage.count[mbps_pkg::ADDR_W-1:mbps_pkg::LEN_W] != '0) |
                    (stage.count[mbps_pkg::LEN_W-1:0] >= active_len);
      fire_match  = ~reported_ff & seen_enough & window_hit;
      fire_miss   = stage.last & ~reported_ff & ~fire_match;

      valid_in    = valid_ff & rsp_stall;
      found_in    = found_ff;
      addr_in     = addr_ff;
      reported_in = reported_ff;
      if (advance) begin
         if (fire_match | fire_miss) begin
            valid_in = 1'b1;
            found_in = fire_match;
            addr_in  = fire_match ? stage.count + addr_adjust : '0;
         end
         // restart the region after its final byte
         reported_in = stage.last ? 1'b0 : (reported_ff | fire_match);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         reported_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         reported_ff <= reported_in;
      end
      found_ff <= found_in;
      addr_ff  <= addr_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_match_address = addr_ff;

   `MBPS_ASSERT_SAME(a_miss_addr_zero, valid_ff && !found_ff, addr_ff == '0, "not-found result carries nonzero address")
   `MBPS_ASSERT_NEXT(a_match_reported, advance && fire_match, valid_ff && found_ff, "match did not reach result register")
   `MBPS_ASSERT_NEXT(a_region_restart, advance && stage.last, !reported_ff, "report flag survived region end")
   `MBPS_ASSERT_SAME(a_hold_only_stalled, stage.valid && !advance, valid_ff && rsp_stall, "pending byte held without a stalled result")

endmodule

`default_nettype wire
